@@ rtl/rua_pkg.sv @@
// ----------------------------------------------------------------------------
// rua_pkg
// Shared constants, command/status types and the modular reduction helper
// for the rectangle union area block.
// ----------------------------------------------------------------------------
package rua_pkg;

    localparam int MAX_RECTS_DEF  = 256;
    localparam int COORD_BITS_DEF = 30;
    localparam int MOD_BITS       = 30;
    localparam logic [MOD_BITS:0] AREA_MOD = 31'd1000000007;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_XCOMMIT,
        OP_YSTART,
        OP_YCOMMIT,
        OP_MULSTART,
        OP_EVCHK,
        OP_YDONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   rect_we;
        logic   scan_valid;
        logic   scan_y;
        logic   iv_cap;
        logic   iv_proc;
    } dp_cmd_t;

    typedef struct packed {
        logic cand_found;
        logic have_prev;
        logic ev_match;
        logic mul_done;
    } dp_stat_t;

    // Reduce a value below three times the modulus into [0, modulus)
    function automatic logic [MOD_BITS-1:0] mod_reduce(input logic [MOD_BITS:0] v);
        logic [MOD_BITS:0] r;
        begin
            if (v >= (AREA_MOD << 1))
                r = v - (AREA_MOD << 1);
            else if (v >= AREA_MOD)
                r = v - AREA_MOD;
            else
                r = v;
            return r[MOD_BITS-1:0];
        end
    endfunction

endpackage

@@ rtl/rua_ram.sv @@
// ----------------------------------------------------------------------------
// rua_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rua_mulmod.sv @@
// ----------------------------------------------------------------------------
// rua_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module rua_mulmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [rua_pkg::MOD_BITS-1:0]  a,
    input  logic [rua_pkg::MOD_BITS-1:0]  b,
    output logic                          done,
    output logic [rua_pkg::MOD_BITS-1:0]  prod
);
    import rua_pkg::*;

    localparam int CW = $clog2(MOD_BITS + 1);

    logic [MOD_BITS-1:0] a_reg, b_reg, acc_reg;
    logic [MOD_BITS-1:0] a_next, b_next, acc_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                run_reg, run_next, done_reg, done_next;
    logic [MOD_BITS:0]   dbl, dbl_r, sum;
    logic [MOD_BITS-1:0] dbl_m;

    // One step: double, reduce, add a when the bit is set, reduce
    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= AREA_MOD) ? dbl - AREA_MOD : dbl;
        dbl_m = dbl_r[MOD_BITS-1:0];
        sum   = {1'b0, dbl_m} + (b_reg[MOD_BITS-1] ? {1'b0, a_reg} : '0);
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = CW'(MOD_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = (sum >= AREA_MOD) ? MOD_BITS'(sum - AREA_MOD) : sum[MOD_BITS-1:0];
            b_next   = {b_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/rua_dp.sv @@
// ----------------------------------------------------------------------------
// rua_dp
// Datapath: rectangle store, sorted x list, coverage counts, candidate
// search, covered width tracking and area accumulation.
// ----------------------------------------------------------------------------
module rua_dp #(
    parameter int MAX_RECTS  = rua_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = rua_pkg::COORD_BITS_DEF,
    parameter int RA_W       = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    parameter int XA_W       = $clog2(2 * MAX_RECTS),
    parameter int CV_W       = $clog2(MAX_RECTS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rua_pkg::dp_cmd_t              cmd,
    output rua_pkg::dp_stat_t             stat,
    input  logic [COORD_BITS-1:0]         x_left,
    input  logic [COORD_BITS-1:0]         y_bottom,
    input  logic [COORD_BITS-1:0]         x_right,
    input  logic [COORD_BITS-1:0]         y_top,
    input  logic [RA_W-1:0]               rect_waddr,
    input  logic [RA_W-1:0]               rect_raddr,
    input  logic [XA_W-1:0]               xs_waddr,
    input  logic [XA_W-1:0]               xs_raddr,
    input  logic [XA_W-1:0]               cov_waddr,
    input  logic [XA_W-1:0]               cov_raddr,
    output logic [rua_pkg::MOD_BITS-1:0]  area_mod
);
    import rua_pkg::*;

    localparam int CB = COORD_BITS;

    logic [4*CB-1:0] rect_q;
    logic [CB-1:0]   xs_q;
    logic [CV_W-1:0] cov_q, cov_wdata;
    logic            cov_we, xs_we;

    logic [CB-1:0] q_l, q_b, q_r, q_t, v0, v1, pick, diff;
    logic          nondeg, ok0, ok1, covering;

    logic [CB-1:0]       cand_reg, cur_reg, prev_y_reg, width_reg, prev_x_reg;
    logic [CB-1:0]       hold_l_reg, hold_r_reg;
    logic                found_reg, cur_vld_reg, have_prev_reg, hold_open_reg;
    logic [MOD_BITS-1:0] area_reg;

    logic                mul_done;
    logic [MOD_BITS-1:0] mul_prod, mul_a, mul_b;
    logic [MOD_BITS:0]   area_sum;

    rua_ram #(.WIDTH(4 * CB), .DEPTH(MAX_RECTS), .AW(RA_W)) u_rect_ram (
        .clk   (clk),
        .we    (cmd.rect_we),
        .waddr (rect_waddr),
        .wdata ({x_left, y_bottom, x_right, y_top}),
        .raddr (rect_raddr),
        .rdata (rect_q)
    );

    rua_ram #(.WIDTH(CB), .DEPTH(2 * MAX_RECTS), .AW(XA_W)) u_xs_ram (
        .clk   (clk),
        .we    (xs_we),
        .waddr (xs_waddr),
        .wdata (cand_reg),
        .raddr (xs_raddr),
        .rdata (xs_q)
    );

    rua_ram #(.WIDTH(CV_W), .DEPTH(2 * MAX_RECTS), .AW(XA_W)) u_cov_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata),
        .raddr (cov_raddr),
        .rdata (cov_q)
    );

    // Reduce width and y gap into the multiplier
    assign mul_a = mod_reduce((MOD_BITS + 1)'(width_reg));
    assign mul_b = mod_reduce((MOD_BITS + 1)'(cur_reg - prev_y_reg));

    rua_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.op == OP_MULSTART),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Split the stored rectangle word and pick the next candidate coordinate
    always_comb
    begin
        q_l    = rect_q[4*CB-1 -: CB];
        q_b    = rect_q[3*CB-1 -: CB];
        q_r    = rect_q[2*CB-1 -: CB];
        q_t    = rect_q[CB-1 -: CB];
        nondeg = (q_r > q_l) && (q_t > q_b);
        v0     = cmd.scan_y ? q_b : q_l;
        v1     = cmd.scan_y ? q_t : q_r;
        ok0    = nondeg && (!cur_vld_reg || (v0 > cur_reg));
        ok1    = nondeg && (!cur_vld_reg || (v1 > cur_reg));
        pick   = ok0 ? v0 : v1;
    end

    // Interval test and coverage update
    always_comb
    begin
        diff      = xs_q - prev_x_reg;
        covering  = (prev_x_reg >= hold_l_reg) && (xs_q <= hold_r_reg);
        xs_we     = (cmd.op == OP_XCOMMIT);
        cov_we    = xs_we || (cmd.iv_proc && covering);
        if (xs_we)
            cov_wdata = '0;
        else if (hold_open_reg)
            cov_wdata = cov_q + 1'b1;
        else
            cov_wdata = cov_q - 1'b1;
        area_sum  = {1'b0, area_reg} + {1'b0, mul_prod};
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            cur_vld_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR, OP_YSTART:
                begin
                    found_reg     <= 1'b0;
                    cur_vld_reg   <= 1'b0;
                    have_prev_reg <= 1'b0;
                end
                OP_XCOMMIT, OP_YCOMMIT:
                begin
                    found_reg   <= 1'b0;
                    cur_vld_reg <= 1'b1;
                end
                OP_YDONE:
                begin
                    have_prev_reg <= 1'b1;
                end
                default:
                begin
                    if (cmd.scan_valid && (ok0 || ok1))
                    begin
                        found_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Datapath values
    always_ff @(posedge clk)
    begin
        if (cmd.scan_valid && (ok0 || ok1) && (!found_reg || (pick < cand_reg)))
        begin
            cand_reg <= pick;
        end
        if ((cmd.op == OP_XCOMMIT) || (cmd.op == OP_YCOMMIT))
        begin
            cur_reg <= cand_reg;
        end
        if (cmd.op == OP_YDONE)
        begin
            prev_y_reg <= cur_reg;
        end
        if (cmd.op == OP_EVCHK)
        begin
            hold_l_reg    <= q_l;
            hold_r_reg    <= q_r;
            hold_open_reg <= (q_b == cur_reg);
        end
        if (cmd.iv_cap)
        begin
            prev_x_reg <= xs_q;
        end
        if (cmd.op == OP_CLEAR)
        begin
            width_reg <= '0;
            area_reg  <= '0;
        end
        else
        begin
            if (cmd.iv_proc && covering && hold_open_reg && (cov_q == '0))
                width_reg <= width_reg + diff;
            else if (cmd.iv_proc && covering && !hold_open_reg && (cov_q == CV_W'(1)))
                width_reg <= width_reg - diff;
            if (mul_done)
                area_reg <= mod_reduce(area_sum);
        end
    end

    assign stat.cand_found = found_reg;
    assign stat.have_prev  = have_prev_reg;
    assign stat.ev_match   = nondeg && ((q_b == cur_reg) || (q_t == cur_reg));
    assign stat.mul_done   = mul_done;
    assign area_mod        = area_reg;

endmodule

@@ rtl/rua_ctrl.sv @@
// ----------------------------------------------------------------------------
// rua_ctrl
// Controller: loads rectangles, then sequences x list build, y sweep,
// per-event coverage scans and the result strobe.
// ----------------------------------------------------------------------------
module rua_ctrl #(
    parameter int MAX_RECTS = rua_pkg::MAX_RECTS_DEF,
    parameter int RA_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    parameter int XA_W      = $clog2(2 * MAX_RECTS),
    parameter int CNT_W     = $clog2(MAX_RECTS + 1),
    parameter int XN_W      = $clog2(2 * MAX_RECTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last_rect,
    output logic               busy,
    output logic               done,
    output logic               overflowed,
    output rua_pkg::dp_cmd_t   cmd,
    input  rua_pkg::dp_stat_t  stat,
    output logic [RA_W-1:0]    rect_waddr,
    output logic [RA_W-1:0]    rect_raddr,
    output logic [XA_W-1:0]    xs_waddr,
    output logic [XA_W-1:0]    xs_raddr,
    output logic [XA_W-1:0]    cov_waddr,
    output logic [XA_W-1:0]    cov_raddr
);
    import rua_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XSCAN,
        S_XNEXT,
        S_YSCAN,
        S_YNEXT,
        S_MULGO,
        S_MULWAIT,
        S_EVRD,
        S_EVCHK,
        S_IVSCAN,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [XN_W-1:0]  cnt_reg, cnt_next, nx_reg, nx_next, n_ext;
    logic [CNT_W-1:0] ev_reg, ev_next, count_reg, count_next;
    logic             ovf_reg, ovf_next, done_reg, done_next, oflow_reg, oflow_next;

    assign n_ext = XN_W'(count_reg);

    // Next state, counters and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        nx_next    = nx_reg;
        ev_next    = ev_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        oflow_next = oflow_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        rect_raddr = cnt_reg[RA_W-1:0];
        xs_raddr   = cnt_reg[XA_W-1:0];
        cov_raddr  = XA_W'(cnt_reg - 1'b1);
        cov_waddr  = nx_reg[XA_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < CNT_W'(MAX_RECTS))
                    begin
                        cmd.rect_we = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_rect)
                    begin
                        cmd.op     = OP_CLEAR;
                        cnt_next   = '0;
                        nx_next    = '0;
                        state_next = S_XSCAN;
                    end
                end
            end
            S_XSCAN, S_YSCAN:
            begin
                cmd.scan_y     = (state_reg == S_YSCAN);
                cmd.scan_valid = (cnt_reg != '0);
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == n_ext)
                begin
                    state_next = (state_reg == S_XSCAN) ? S_XNEXT : S_YNEXT;
                end
            end
            S_XNEXT:
            begin
                cnt_next = '0;
                if (stat.cand_found)
                begin
                    cmd.op     = OP_XCOMMIT;
                    nx_next    = nx_reg + 1'b1;
                    state_next = S_XSCAN;
                end
                else
                begin
                    cmd.op     = OP_YSTART;
                    state_next = S_YSCAN;
                end
            end
            S_YNEXT:
            begin
                ev_next = '0;
                if (!stat.cand_found)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_YCOMMIT;
                    state_next = stat.have_prev ? S_MULGO : S_EVRD;
                end
            end
            S_MULGO:
            begin
                cmd.op     = OP_MULSTART;
                state_next = S_MULWAIT;
            end
            S_MULWAIT:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_EVRD;
                end
            end
            S_EVRD:
            begin
                rect_raddr = ev_reg[RA_W-1:0];
                if (ev_reg == count_reg)
                begin
                    cmd.op     = OP_YDONE;
                    cnt_next   = '0;
                    state_next = S_YSCAN;
                end
                else
                begin
                    state_next = S_EVCHK;
                end
            end
            S_EVCHK:
            begin
                cmd.op   = OP_EVCHK;
                cnt_next = '0;
                if (stat.ev_match)
                begin
                    state_next = S_IVSCAN;
                end
                else
                begin
                    ev_next    = ev_reg + 1'b1;
                    state_next = S_EVRD;
                end
            end
            S_IVSCAN:
            begin
                // read x[k] and cover[k-1]; update cover[k-2] from last cycle's data
                cov_waddr   = XA_W'(cnt_reg - 2'd2);
                cmd.iv_cap  = (cnt_reg != '0);
                cmd.iv_proc = (cnt_reg >= XN_W'(2));
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == nx_reg)
                begin
                    ev_next    = ev_reg + 1'b1;
                    state_next = S_EVRD;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                oflow_next = ovf_reg;
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            nx_reg    <= '0;
            ev_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
            oflow_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nx_reg    <= nx_next;
            ev_reg    <= ev_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
            oflow_reg <= oflow_next;
        end
    end

    assign rect_waddr = count_reg[RA_W-1:0];
    assign xs_waddr   = nx_reg[XA_W-1:0];
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign overflowed = oflow_reg;

endmodule

@@ rtl/rectangle_union_area.sv @@
// ----------------------------------------------------------------------------
// rectangle_union_area
// Union area of axis-aligned rectangles, modulo 1000000007, by a y sweep
// over the sorted distinct x coordinates with per-interval coverage counts.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+---------------------------
//   rect in  | input     | start high, busy low   | x_left y_bottom x_right
//            |           |                        | y_top last_rect
//   result   | output    | done, one-cycle strobe | area_mod overflowed
//
// A rectangle word without last_rect is taken in one cycle; busy stays low.
// With last_rect, busy rises and the computation runs, made up of the
// one-word-per-cycle scans of the rectangle and x RAMs over the distinct x and
// y values of nondegenerate rectangles only, per-event interval scans of the x
// list for each matching edge and a bit-serial multiply per y gap.
// done pulses in the cycle busy falls; the receiver cannot stall it.
// Reset clears the state, counts and flags only.
// ----------------------------------------------------------------------------
module rectangle_union_area #(
    parameter int MAX_RECTS  = rua_pkg::MAX_RECTS_DEF,
    parameter int COORD_BITS = rua_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         x_left,
    input  logic [COORD_BITS-1:0]         y_bottom,
    input  logic [COORD_BITS-1:0]         x_right,
    input  logic [COORD_BITS-1:0]         y_top,
    input  logic                          last_rect,
    output logic                          done,
    output logic [rua_pkg::MOD_BITS-1:0]  area_mod,
    output logic                          overflowed
);
    import rua_pkg::*;

    localparam int RA_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int XA_W  = $clog2(2 * MAX_RECTS);
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int XN_W  = $clog2(2 * MAX_RECTS + 1);

    dp_cmd_t         cmd;
    dp_stat_t        stat;
    logic [RA_W-1:0] rect_waddr, rect_raddr;
    logic [XA_W-1:0] xs_waddr, xs_raddr, cov_waddr, cov_raddr;

    rua_ctrl #(
        .MAX_RECTS (MAX_RECTS),
        .RA_W      (RA_W),
        .XA_W      (XA_W),
        .CNT_W     (CNT_W),
        .XN_W      (XN_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_rect  (last_rect),
        .busy       (busy),
        .done       (done),
        .overflowed (overflowed),
        .cmd        (cmd),
        .stat       (stat),
        .rect_waddr (rect_waddr),
        .rect_raddr (rect_raddr),
        .xs_waddr   (xs_waddr),
        .xs_raddr   (xs_raddr),
        .cov_waddr  (cov_waddr),
        .cov_raddr  (cov_raddr)
    );

    rua_dp #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS),
        .RA_W       (RA_W),
        .XA_W       (XA_W),
        .CV_W       (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .x_left     (x_left),
        .y_bottom   (y_bottom),
        .x_right    (x_right),
        .y_top      (y_top),
        .rect_waddr (rect_waddr),
        .rect_raddr (rect_raddr),
        .xs_waddr   (xs_waddr),
        .xs_raddr   (xs_raddr),
        .cov_waddr  (cov_waddr),
        .cov_raddr  (cov_raddr),
        .area_mod   (area_mod)
    );

endmodule

@@ rtl/rua_checker.sv @@
// ----------------------------------------------------------------------------
// rua_checker
// Port-level checks of the rectangle union area block, bound to the top.
// ----------------------------------------------------------------------------
module rua_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          last_rect,
    input logic                          done,
    input logic [rua_pkg::MOD_BITS-1:0]  area_mod
);
    import rua_pkg::*;

    // A result word appears only once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // Strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // A final word starts a computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_rect) |=> busy)
        else $error("last word did not start computation");

    // The end of a computation delivers a result
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("computation ended without result");

    // Area is reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, area_mod} < AREA_MOD))
        else $error("area not reduced");

endmodule

bind rectangle_union_area rua_checker u_rua_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Loads rectangle sets into rectangle_union_area and checks each union area
// and overflow flag against a sweep-line predictor kept in the bench. Covers
// corner coordinates, degenerate rectangles, full capacity with and without
// dropped words, and random runs with and without idle gaps on the sender.
// ----------------------------------------------------------------------------
module testbench;

    import rua_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam longint unsigned MODV = longint'(AREA_MOD);

    typedef struct packed {
        logic [CB-1:0] xl;
        logic [CB-1:0] yb;
        logic [CB-1:0] xr;
        logic [CB-1:0] yt;
    } rect_t;

    typedef struct {
        logic [MOD_BITS-1:0] area;
        logic                ovf;
    } answer_t;

    typedef struct {
        longint unsigned y;
        int              lo;
        int              hi;
        bit              open;
    } sweep_ev_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CB-1:0]       x_left;
    logic [CB-1:0]       y_bottom;
    logic [CB-1:0]       x_right;
    logic [CB-1:0]       y_top;
    logic                last_rect;
    logic                done;
    logic [MOD_BITS-1:0] area_mod;
    logic                overflowed;

    rect_t   loaded_rects[$];
    bit      dropped;
    answer_t pending_answers[$];
    int      fail_count;
    int      words_sent;
    bit      idle_enable;

    rectangle_union_area dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_left     (x_left),
        .y_bottom   (y_bottom),
        .x_right    (x_right),
        .y_top      (y_top),
        .last_rect  (last_rect),
        .done       (done),
        .area_mod   (area_mod),
        .overflowed (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Union area modulo the prime by a y sweep over compressed x intervals
    function automatic logic [MOD_BITS-1:0] union_area_mod(rect_t rs[$]);
        longint unsigned xs[$];
        longint unsigned ux[$];
        longint unsigned v;
        longint unsigned prev;
        longint unsigned width;
        longint unsigned acc;
        sweep_ev_t       evs[$];
        sweep_ev_t       ev;
        int              cov[];
        int              i;
        int              j;
        int              li;
        int              ri;
        begin
            foreach (rs[k])
            begin
                xs.insert(xs.size(), 64'(rs[k].xl));
                xs.insert(xs.size(), 64'(rs[k].xr));
            end
            // sort x values, then drop repeats
            for (i = 1; i < xs.size(); i++)
            begin
                v = xs[i];
                j = i;
                while (j > 0 && xs[j-1] > v)
                begin
                    xs[j] = xs[j-1];
                    j--;
                end
                xs[j] = v;
            end
            foreach (xs[k])
                if (ux.size() == 0 || ux[ux.size()-1] != xs[k])
                    ux.insert(ux.size(), xs[k]);
            // build open and close edges of covering rectangles
            foreach (rs[k])
            begin
                if (rs[k].xr <= rs[k].xl || rs[k].yt <= rs[k].yb)
                    continue;
                li = 0;
                ri = 0;
                foreach (ux[m])
                begin
                    if (ux[m] == rs[k].xl) li = m;
                    if (ux[m] == rs[k].xr) ri = m;
                end
                ev.y    = 64'(rs[k].yb);
                ev.lo   = li;
                ev.hi   = ri;
                ev.open = 1'b1;
                evs.insert(evs.size(), ev);
                ev.y    = 64'(rs[k].yt);
                ev.open = 1'b0;
                evs.insert(evs.size(), ev);
            end
            for (i = 1; i < evs.size(); i++)
            begin
                ev = evs[i];
                j = i;
                while (j > 0 && evs[j-1].y > ev.y)
                begin
                    evs[j] = evs[j-1];
                    j--;
                end
                evs[j] = ev;
            end
            // sweep: add covered width times each y gap
            cov = new[ux.size() + 1];
            foreach (cov[k]) cov[k] = 0;
            acc = 0;
            prev = 0;
            foreach (evs[k])
            begin
                if (k > 0 && evs[k].y != prev)
                begin
                    width = 0;
                    for (i = 0; i + 1 < ux.size(); i++)
                        if (cov[i] != 0)
                            width += ux[i+1] - ux[i];
                    acc = (acc + (width % MODV) * ((evs[k].y - prev) % MODV)) % MODV;
                end
                prev = evs[k].y;
                for (i = evs[k].lo; i < evs[k].hi; i++)
                    cov[i] += evs[k].open ? 1 : -1;
            end
            return acc[MOD_BITS-1:0];
        end
    endfunction

    // Track the loaded set; predict an answer when the set closes
    task automatic load_rect(input rect_t r, input bit last);
        answer_t ans;
        begin
            if (loaded_rects.size() < MAX_RECTS_DEF)
                loaded_rects.insert(loaded_rects.size(), r);
            else
                dropped = 1'b1;
            if (last)
            begin
                ans.area = union_area_mod(loaded_rects);
                ans.ovf  = dropped;
                pending_answers.insert(pending_answers.size(), ans);
                loaded_rects.delete();
                dropped = 1'b0;
            end
        end
    endtask

    // Send one word; hold it until accepted
    task automatic send_rect(input rect_t r, input bit last);
        int gap;
        begin
            if (idle_enable && $urandom_range(99) < 5)
            begin
                start <= 1'b0;
                gap = $urandom_range(1, 2);
                repeat (gap) @(posedge clk);
            end
            start     <= 1'b1;
            x_left    <= r.xl;
            y_bottom  <= r.yb;
            x_right   <= r.xr;
            y_top     <= r.yt;
            last_rect <= last;
            @(posedge clk);
            while (busy) @(posedge clk);
            load_rect(r, last);
            words_sent++;
        end
    endtask

    // Stop sending until every pending answer has arrived
    task automatic wait_drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_answers.size() != 0 || busy) @(posedge clk);
        end
    endtask

    function automatic rect_t mk(input longint unsigned xl, input longint unsigned yb,
                                 input longint unsigned xr, input longint unsigned yt);
        rect_t r;
        begin
            r.xl = xl[CB-1:0];
            r.yb = yb[CB-1:0];
            r.xr = xr[CB-1:0];
            r.yt = yt[CB-1:0];
            return r;
        end
    endfunction

    function automatic logic [CB-1:0] rand_coord(input int mode);
        logic [31:0] raw;
        begin
            case (mode)
                0: raw = $urandom_range(63);
                1: raw = $urandom_range(1000000000);
                2: raw = $urandom_range(32'h3FFF_FFFF, 32'h3FFF_FF00);
                default: raw = $urandom() & 32'h3FFF_FFFF;
            endcase
            return raw[CB-1:0];
        end
    endfunction

    function automatic rect_t rand_rect(input int mode);
        logic [CB-1:0] a;
        logic [CB-1:0] b;
        logic [CB-1:0] c;
        logic [CB-1:0] d;
        rect_t         r;
        begin
            a = rand_coord(mode);
            b = rand_coord(mode);
            c = rand_coord(mode);
            d = rand_coord(mode);
            // mostly well-formed, sometimes inverted or flat
            if ($urandom_range(99) < 90)
            begin
                r.xl = (a < b) ? a : b;
                r.yb = (c < d) ? c : d;
                r.xr = (a < b) ? b : a;
                r.yt = (c < d) ? d : c;
            end
            else
            begin
                r.xl = a;
                r.yb = c;
                r.xr = b;
                r.yt = d;
            end
            return r;
        end
    endfunction

    // Check each answer against the oldest prediction
    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected answer: area_mod=%0d overflowed=%0d", area_mod, overflowed);
                fail_count++;
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (area_mod !== exp_ans.area)
                begin
                    $error("area_mod: expected %0d, actual %0d", exp_ans.area, area_mod);
                    fail_count++;
                end
                if (overflowed !== exp_ans.ovf)
                begin
                    $error("overflowed: expected %0d, actual %0d", exp_ans.ovf, overflowed);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_corners();
        longint unsigned top;
        begin
            top = 64'h3FFF_FFFF;
            // full range square, coordinates above 1e9
            send_rect(mk(0, 0, top, top), 1'b1);
            // flat and inverted covers nothing
            send_rect(mk(5, 5, 5, 9), 1'b0);
            send_rect(mk(9, 9, 3, 3), 1'b1);
            // all x equal
            send_rect(mk(7, 0, 7, 100), 1'b0);
            send_rect(mk(7, 3, 7, 50), 1'b1);
            // overlap, nesting and a shared edge
            send_rect(mk(0, 0, 10, 10), 1'b0);
            send_rect(mk(5, 5, 15, 15), 1'b0);
            send_rect(mk(2, 2, 4, 4), 1'b0);
            send_rect(mk(15, 0, 20, 15), 1'b1);
            // near the modulus and past 1e9
            send_rect(mk(0, 0, 1000000000, 1000000000), 1'b1);
            send_rect(mk(1000000000, 1000000001, top, top), 1'b0);
            send_rect(mk(0, 0, 1, top), 1'b1);
            // alternating bit patterns
            send_rect(mk(30'h1555_5555, 30'h0AAA_AAAA, 30'h2AAA_AAAA, 30'h3555_5555), 1'b1);
            send_rect(mk(0, 0, 1, 1), 1'b1);
            wait_drain();
        end
    endtask

    task automatic test_capacity();
        int i;
        begin
            // exactly full: nothing dropped
            for (i = 0; i < MAX_RECTS_DEF; i++)
                send_rect(rand_rect(0), i == MAX_RECTS_DEF - 1);
            // past full: extra words dropped, last still answered
            for (i = 0; i < MAX_RECTS_DEF + 4; i++)
                send_rect(rand_rect(0), i == MAX_RECTS_DEF + 3);
            wait_drain();
        end
    endtask

    task automatic test_random(input int target, input bit with_idle);
        int set_size;
        int mode;
        int i;
        begin
            idle_enable = with_idle;
            while (words_sent < target)
            begin
                set_size = ($urandom_range(9) == 0) ? $urandom_range(9, 30)
                                                    : $urandom_range(1, 8);
                mode = $urandom_range(3);
                for (i = 0; i < set_size; i++)
                    send_rect(rand_rect(mode), i == set_size - 1);
                if ($urandom_range(19) == 0)
                    wait_drain();
            end
            idle_enable = 1'b1;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        x_left      = '0;
        y_bottom    = '0;
        x_right     = '0;
        y_top       = '0;
        last_rect   = 1'b0;
        fail_count  = 0;
        words_sent  = 0;
        dropped     = 1'b0;
        idle_enable = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_capacity();
        test_random(words_sent + 150, 1'b0);
        test_random(words_sent + 370, 1'b1);
        wait_drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
